FILE: rtl/rbf_pkg.sv
package rbf_pkg;

    localparam int LANES      = 4;
    localparam int ELEM_W     = 16;
    localparam int CNT_W      = 3;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 48;
    localparam int GAMMA_W    = 24;
    localparam int KV_W       = 17;
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int Q_W        = 25;
    localparam int IP_W       = PROD_W - 44;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;
    localparam logic [MUL_W-1:0]   LOG2E_Q24   = 25'd24204406;
    localparam logic [Q_W-1:0]     Q_MAX       = {Q_W{1'b1}};

    localparam logic REG_GAMMA = 1'b0;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             sat;
    } acc_status_t;

    // long division by shift and subtract
    function automatic longint unsigned udiv_small(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // entry k of the 2^-f table, k/2^idx_w being the fraction, in Q1.16
    function automatic logic [KV_W-1:0] pow2_entry(input longint unsigned k,
                                                   input int unsigned idx_w);
        longint unsigned y;
        longint unsigned term;
        longint          acc;
        longint unsigned rnd;
        y    = (k * 64'd744261118) >> idx_w;
        term = 64'd1 << 30;
        acc  = longint'(64'd1 << 30);
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv_small((term * y) >> 30, 64'(n));
            if ((n & 1) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rnd = (longint'(acc) + 64'd8192) >> 14;
        return rnd[KV_W-1:0];
    endfunction

endpackage

FILE: rtl/rbf_if.sv
interface rbf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_lane0;
    logic signed [15:0] a_lane1;
    logic signed [15:0] a_lane2;
    logic signed [15:0] a_lane3;
    logic signed [15:0] b_lane0;
    logic signed [15:0] b_lane1;
    logic signed [15:0] b_lane2;
    logic signed [15:0] b_lane3;
    logic [2:0]         lanes_valid;
    logic               last_elements;

    modport source (
        output valid, a_lane0, a_lane1, a_lane2, a_lane3,
               b_lane0, b_lane1, b_lane2, b_lane3, lanes_valid, last_elements,
        input  ready
    );
    modport sink (
        input  valid, a_lane0, a_lane1, a_lane2, a_lane3,
               b_lane0, b_lane1, b_lane2, b_lane3, lanes_valid, last_elements,
        output ready
    );
endinterface

interface rbf_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] kernel_value;
    logic        distance_saturated;

    modport source (
        output valid, kernel_value, distance_saturated,
        input  ready
    );
    modport sink (
        input  valid, kernel_value, distance_saturated,
        output ready
    );
endinterface

FILE: rtl/rbf_kernel_entry.sv
// non-last item: absorbed at one item per cycle when idle; lane square register, then sum
// last item: result formed in MHI, MLO, QSAT, MLOG, LOOK, SHIFT by the shared 25x25
//   multiplier (three passes) and the registered 2^-f table read
// after a last item the next item is accepted the cycle after the result is taken
// reset: gamma = 1.0, sum and saturation flag cleared; the table is constant logic
module rbf_kernel_entry #(
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rbf_in_if.sink                          in_ch,
    rbf_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rbf_pkg::PADDR_W-1:0]     paddr,
    input  logic [rbf_pkg::PDATA_W-1:0]     pwdata,
    output logic [rbf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import rbf_pkg::*;

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MHI   = 3'd1;
    localparam logic [2:0] ST_MLO   = 3'd2;
    localparam logic [2:0] ST_QSAT  = 3'd3;
    localparam logic [2:0] ST_MLOG  = 3'd4;
    localparam logic [2:0] ST_LOOK  = 3'd5;
    localparam logic [2:0] ST_SHIFT = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [GAMMA_W-1:0]  gamma_reg;
    logic                pend_reg;
    stage_ctl_t          s1_ctl_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM_W-1:0]    ph_reg;
    logic [Q_W-1:0]      q_reg;
    logic [IP_W-1:0]     ip_reg;
    logic                out_valid_reg;
    logic [KV_W-1:0]     kv_reg;
    logic                dsat_reg;

    logic signed [ELEM_W-1:0] a_v [LANES];
    logic signed [ELEM_W-1:0] b_v [LANES];
    logic [SQ_W-1:0]          sq_v [LANES];
    acc_status_t              acc_status;
    logic                     in_acc;
    logic                     out_acc;
    logic                     start;
    logic                     cfg_wr;
    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [SUM_W+4:0]         q_full;
    logic [KV_W-1:0]          rom_data;
    logic [IDX_W-1:0]         rom_addr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[PADDR_W-1] == REG_GAMMA) ? PDATA_W'(gamma_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamma_reg <= GAMMA_RESET;
        else if (cfg_wr && paddr[PADDR_W-1] == REG_GAMMA)
            gamma_reg <= pwdata[GAMMA_W-1:0];
    end

    // lanes
    assign in_ch.ready = (state_reg == ST_IDLE) && !pend_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_ch.valid && out_ch.ready;

    assign a_v[0] = in_ch.a_lane0;
    assign a_v[1] = in_ch.a_lane1;
    assign a_v[2] = in_ch.a_lane2;
    assign a_v[3] = in_ch.a_lane3;
    assign b_v[0] = in_ch.b_lane0;
    assign b_v[1] = in_ch.b_lane1;
    assign b_v[2] = in_ch.b_lane2;
    assign b_v[3] = in_ch.b_lane3;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        rbf_lane u_lane (
            .clk (clk),
            .a   (a_v[i]),
            .b   (b_v[i]),
            .en  (in_ch.lanes_valid > CNT_W'(i)),
            .sq  (sq_v[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg.valid <= in_acc;
            s1_ctl_reg.last  <= in_acc && in_ch.last_elements;
            if (in_acc && in_ch.last_elements)
                pend_reg <= 1'b1;
            else if (start)
                pend_reg <= 1'b0;
        end
    end

    assign start = s1_ctl_reg.valid && s1_ctl_reg.last;

    rbf_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (s1_ctl_reg),
        .sq     (sq_v),
        .clear  (state_reg == ST_SHIFT),
        .status (acc_status)
    );

    // kernel sequencer
    always_comb
    begin
        unique case (state_reg)
            ST_MHI:
            begin
                mul_a = MUL_W'(acc_status.sum[SUM_W-1:24]);
                mul_b = MUL_W'(gamma_reg);
            end
            ST_MLO:
            begin
                mul_a = MUL_W'(acc_status.sum[23:0]);
                mul_b = MUL_W'(gamma_reg);
            end
            ST_MLOG:
            begin
                mul_a = MUL_W'(q_reg);
                mul_b = LOG2E_Q24;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
        q_full   = {1'b0, ph_reg, 4'b0} + (SUM_W+5)'(prod_reg[SUM_W-1:20]);
        rom_addr = prod_reg[43 -: IDX_W];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  state_next = start ? ST_MHI : ST_IDLE;
            ST_MHI:   state_next = ST_MLO;
            ST_MLO:   state_next = ST_QSAT;
            ST_QSAT:  state_next = ST_MLOG;
            ST_MLOG:  state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_OUT;
            ST_OUT:   state_next = out_acc ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    rbf_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SHIFT)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MHI || state_reg == ST_MLO || state_reg == ST_MLOG)
            prod_reg <= mul_p;
        if (state_reg == ST_MLO)
            ph_reg <= prod_reg[SUM_W-1:0];
        if (state_reg == ST_QSAT)
            q_reg <= (q_full > (SUM_W+5)'(Q_MAX)) ? Q_MAX : q_full[Q_W-1:0];
        if (state_reg == ST_LOOK)
            ip_reg <= prod_reg[PROD_W-1:44];
        if (state_reg == ST_SHIFT)
        begin
            kv_reg   <= rom_data >> ip_reg;
            dsat_reg <= acc_status.sat;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.kernel_value       = kv_reg;
    assign out_ch.distance_saturated = dsat_reg;

    a_result_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_OUT)
        else $error("result shown outside output state");

    a_no_item_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> state_reg == ST_IDLE && !pend_reg && !start)
        else $error("item accepted during kernel evaluation");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |=> acc_status.sum == '0 && !acc_status.sat)
        else $error("accumulator not cleared after result");

    a_result_from_shift: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_SHIFT)
        else $error("result raised without evaluation");

endmodule

FILE: rtl/rbf_lane.sv
module rbf_lane (
    input  logic                                clk,
    input  logic signed [rbf_pkg::ELEM_W-1:0]   a,
    input  logic signed [rbf_pkg::ELEM_W-1:0]   b,
    input  logic                                en,
    output logic [rbf_pkg::SQ_W-1:0]            sq
);
    import rbf_pkg::*;

    logic signed [ELEM_W:0] diff;
    logic [ELEM_W-1:0]      mag;
    logic [SQ_W-1:0]        sq_reg;
    logic [SQ_W-1:0]        sq_next;

    always_comb
    begin
        diff = (ELEM_W+1)'(a) - (ELEM_W+1)'(b);
        mag  = diff[ELEM_W] ? ELEM_W'(-diff) : diff[ELEM_W-1:0];
        sq_next = en ? SQ_W'(mag) * SQ_W'(mag) : '0;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
    end

    assign sq = sq_reg;

endmodule

FILE: rtl/rbf_merge.sv
module rbf_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rbf_pkg::stage_ctl_t         ctl,
    input  logic [rbf_pkg::SQ_W-1:0]    sq [rbf_pkg::LANES],
    input  logic                        clear,
    output rbf_pkg::acc_status_t        status
);
    import rbf_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             sat_reg;
    logic             sat_next;
    logic [SUM_W+1:0] total;

    always_comb
    begin
        total = (SUM_W+2)'(sum_reg);
        for (int i = 0; i < LANES; i++)
        begin
            total = total + (SUM_W+2)'(sq[i]);
        end
        if (total > (SUM_W+2)'(SUM_MAX))
        begin
            sum_next = SUM_MAX;
            sat_next = 1'b1;
        end
        else
        begin
            sum_next = total[SUM_W-1:0];
            sat_next = sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (clear)
        begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (ctl.valid)
        begin
            sum_reg <= sum_next;
            sat_reg <= sat_next;
        end
    end

    assign status.sum = sum_reg;
    assign status.sat = sat_reg;

endmodule

FILE: rtl/rbf_exp_rom.sv
module rbf_exp_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic [$clog2(DEPTH)-1:0]    addr,
    output logic [rbf_pkg::KV_W-1:0]    data
);
    import rbf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic [KV_W-1:0] rom [DEPTH];
    logic [KV_W-1:0] data_reg;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_rom
        localparam logic [KV_W-1:0] ENTRY = pow2_entry(longint'(k), IDX_W);
        assign rom[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

FILE: test/tb_rbf_kernel_entry.sv
`timescale 1ns / 100ps

module tb_rbf_kernel_entry;

    import rbf_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam longint unsigned FRAC_MASK = 64'hFFF_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 10;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SAT_BURST = 16400;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic [LANES-1:0][ELEM_W-1:0] a;
        logic [LANES-1:0][ELEM_W-1:0] b;
        logic [CNT_W-1:0]             lanes;
        logic                         last;
    } elem_item_t;

    typedef struct packed {
        logic [KV_W-1:0] kv;
        logic            sat;
    } kernel_result_t;

    typedef struct packed {
        bit                 set_g;
        logic [GAMMA_W-1:0] g;
        elem_item_t         item;
        int unsigned        reps;
        bit                 typed;
        kernel_result_t     want;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    rbf_in_if  pair_ch ();
    rbf_out_if kernel_ch ();

    rbf_kernel_entry #(
        .EXP_TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(pair_ch),
        .out_ch(kernel_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // predictor state
    logic [KV_W-1:0]    exp2_frac [TABLE_DEPTH];
    logic [GAMMA_W-1:0] gamma_cfg = GAMMA_RESET;
    longint unsigned    dist_acc = 0;
    bit                 dist_sat = 1'b0;
    kernel_result_t     kernels_due [$];

    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;
    bit hold_req = 1'b0;
    int errors = 0;
    int items_in = 0;
    int kernels_out = 0;
    int sat_seen = 0;
    int zero_seen = 0;
    int unit_seen = 0;
    int gamma_writes = 0;
    int cycle_count = 0;

    pair_row_t pair_table [17] = '{
        '{1'b0, 24'd0, '{{4{16'h0000}}, {4{16'h0000}}, 3'd4, 1'b1}, 1, 1'b1, '{17'd65536, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h7FFF}}, {4{16'h8000}}, 3'd4, 1'b1}, 1, 1'b1, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{48'h0, 16'h8000}, {48'h0, 16'h7FFF}, 3'd1, 1'b1}, 1, 1'b1,
          '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h1234}}, {4{16'h0000}}, 3'd0, 1'b1}, 1, 1'b1, '{17'd65536, 1'b0}},
        '{1'b0, 24'd0, '{{48'h0, 16'h1000}, {4{16'h0000}}, 3'd1, 1'b1}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0800}}, {4{16'hF800}}, 3'd2, 1'b0}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0800}}, {4{16'hF800}}, 3'd3, 1'b0}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0100}}, {4{16'hFF00}}, 3'd7, 1'b1}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0400}}, {4{16'h0000}}, 3'd5, 1'b0}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0200}}, {4{16'hFE00}}, 3'd6, 1'b1}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b1, 24'd0, '{{4{16'h7FFF}}, {4{16'h8000}}, 3'd4, 1'b1}, 1, 1'b1, '{17'd65536, 1'b0}},
        '{1'b1, 24'hFFFFFF, '{{48'h0, 16'h0001}, {4{16'h0000}}, 3'd1, 1'b1}, 1, 1'b0,
          '{17'd0, 1'b0}},
        '{1'b1, 24'd1, '{{4{16'h1000}}, {4{16'hF000}}, 3'd4, 1'b1}, 1, 1'b0, '{17'd0, 1'b0}},
        '{1'b1, 24'd65536, '{{4{16'h7FFF}}, {4{16'h8000}}, 3'd4, 1'b0}, SAT_BURST, 1'b0,
          '{17'd0, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'h0000}}, {4{16'h0000}}, 3'd4, 1'b1}, 1, 1'b1, '{17'd0, 1'b1}},
        '{1'b0, 24'd0, '{{4{16'h0000}}, {4{16'h0000}}, 3'd4, 1'b1}, 1, 1'b1, '{17'd65536, 1'b0}},
        '{1'b0, 24'd0, '{{4{16'hFFFF}}, {4{16'h0001}}, 3'd4, 1'b1}, 1, 1'b0, '{17'd0, 1'b0}}
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, kernels_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // 2^-f table over the fraction, Q1.16, by alternating series of exp(-f*ln2)
    function automatic void build_exp2_table();
        longint unsigned y;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            y = (64'(k) * LN2_Q30) / TABLE_DEPTH;
            term = 64'd1 << 30;
            acc = 64'sd1 << 30;
            for (int n = 1; n <= 24; n++)
            begin
                term = ((term * y) >> 30) / 64'(n);
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            exp2_frac[k] = KV_W'((64'(acc) + 64'd8192) >> 14);
        end
    endfunction

    function automatic bit kernel_step(input elem_item_t it, output kernel_result_t res);
        int              n;
        longint          d;
        longint unsigned g64;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned q;
        longint unsigned t;
        longint unsigned ip;
        longint unsigned idx;
        n = (it.lanes > LANES) ? LANES : int'(it.lanes);
        for (int l = 0; l < n; l++)
        begin
            d = longint'($signed(it.a[l])) - longint'($signed(it.b[l]));
            if (d < 0)
                d = -d;
            dist_acc = dist_acc + 64'(d) * 64'(d);
            if (dist_acc > 64'(SUM_MAX))
            begin
                dist_acc = 64'(SUM_MAX);
                dist_sat = 1'b1;
            end
        end
        res = '0;
        if (!it.last)
            return 1'b0;
        g64 = 64'(gamma_cfg);
        hi = dist_acc >> 24;
        lo = dist_acc & 64'hFF_FFFF;
        q = ((hi * g64) << 4) + ((lo * g64) >> 20);
        if (q > 64'(Q_MAX))
            q = 64'(Q_MAX);
        t = q * 64'(LOG2E_Q24);
        ip = t >> 44;
        idx = ((t & FRAC_MASK) * TABLE_DEPTH) >> 44;
        res.kv = (ip >= KV_W) ? '0 : KV_W'(exp2_frac[idx] >> ip);
        res.sat = dist_sat;
        dist_acc = 0;
        dist_sat = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(input elem_item_t it, input bit typed, input kernel_result_t want);
        int             gap;
        kernel_result_t res;
        gap = src_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            pair_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.a_lane0 <= it.a[0];
        pair_ch.a_lane1 <= it.a[1];
        pair_ch.a_lane2 <= it.a[2];
        pair_ch.a_lane3 <= it.a[3];
        pair_ch.b_lane0 <= it.b[0];
        pair_ch.b_lane1 <= it.b[1];
        pair_ch.b_lane2 <= it.b[2];
        pair_ch.b_lane3 <= it.b[3];
        pair_ch.lanes_valid <= it.lanes;
        pair_ch.last_elements <= it.last;
        @(posedge clk);
        while (!pair_ch.ready)
            @(posedge clk);
        items_in++;
        if (kernel_step(it, res))
            kernels_due.insert(kernels_due.size(), typed ? want : res);
    endtask

    task automatic write_gamma(input logic [GAMMA_W-1:0] g);
        pair_ch.valid <= 1'b0;
        while (kernels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {REG_GAMMA, 2'b00};
        pwdata <= PDATA_W'(g);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        gamma_cfg = g;
        gamma_writes++;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[GAMMA_W-1:0] !== g)
        begin
            errors++;
            $display("%0t: gamma readback expected %0d got %0d", $time, g, prdata[GAMMA_W-1:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // vectors of 1..6 items with random content, plus some odd lane counts and broken ends
    task automatic random_phase(input logic [GAMMA_W-1:0] g, input bit sq, input bit kq,
                                input bit hold);
        elem_item_t     it;
        kernel_result_t none;
        int             sent;
        int             len;
        int             mode;
        int             scale;
        none = '0;
        sent = 0;
        write_gamma(g);
        src_quiet = sq;
        snk_quiet = kq;
        if (hold)
            hold_req = 1'b1;
        while (sent < PHASE_ITEMS)
        begin
            len = $urandom_range(1, 6);
            mode = $urandom_range(0, 9);
            scale = 1 << $urandom_range(0, 12);
            for (int k = 0; k < len; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    it.a[l] = 16'($urandom);
                    if (mode < 2)
                        it.b[l] = 16'($urandom);
                    else if (mode == 2)
                        it.b[l] = it.a[l];
                    else
                        it.b[l] = it.a[l] + 16'($urandom_range(0, 2 * scale)) - 16'(scale);
                end
                if ($urandom_range(0, 7) == 0)
                    it.lanes = 3'($urandom_range(0, 7));
                else
                    it.lanes = 3'($urandom_range((k == len - 1) ? 1 : 4, 4));
                it.last = (k == len - 1);
                if ($urandom_range(0, 19) == 0)
                    it.last = ~it.last;
                send_item(it, 1'b0, none);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        elem_item_t it;
        pair_ch.valid <= 1'b0;
        pair_ch.a_lane0 <= '0;
        pair_ch.a_lane1 <= '0;
        pair_ch.a_lane2 <= '0;
        pair_ch.a_lane3 <= '0;
        pair_ch.b_lane0 <= '0;
        pair_ch.b_lane1 <= '0;
        pair_ch.b_lane2 <= '0;
        pair_ch.b_lane3 <= '0;
        pair_ch.lanes_valid <= '0;
        pair_ch.last_elements <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        build_exp2_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pair_table[r])
        begin
            if (pair_table[r].set_g)
                write_gamma(pair_table[r].g);
            src_quiet = (pair_table[r].reps > 1);
            it = pair_table[r].item;
            repeat (pair_table[r].reps)
                send_item(it, pair_table[r].typed, pair_table[r].want);
        end

        random_phase(24'd65536, 1'b0, 1'b0, 1'b0);
        random_phase(24'd0, 1'b1, 1'b0, 1'b0);
        random_phase(24'hFFFFFF, 1'b0, 1'b1, 1'b0);
        random_phase(24'($urandom_range(1, 4096)), 1'b1, 1'b0, 1'b1);
        random_phase(24'($urandom), 1'b0, 1'b0, 1'b0);
        random_phase(24'd1, 1'b1, 1'b1, 1'b0);
        random_phase(24'($urandom_range(65536, 1048576)), 1'b0, 1'b0, 1'b0);

        pair_ch.valid <= 1'b0;
        while (kernels_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (kernels_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, kernels_due.size());
        end
        $display("%0d items in, %0d kernel values checked over %0d gamma settings",
                 items_in, kernels_out, gamma_writes);
        $display("%0d with saturated distance, %0d at zero, %0d at one; %0d errors",
                 sat_seen, zero_seen, unit_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : kernel_sink
        kernel_result_t want;
        int             gap;
        kernel_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = snk_quiet ? 0 : $urandom_range(0, 15);
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                kernel_ch.ready <= 1'b0;
                for (int c = 0; c < gap; c++)
                    @(posedge clk);
            end
            kernel_ch.ready <= 1'b1;
            @(posedge clk);
            while (!kernel_ch.valid)
                @(posedge clk);
            kernels_out++;
            if (kernel_ch.distance_saturated)
                sat_seen++;
            if (kernel_ch.kernel_value == 0)
                zero_seen++;
            if (kernel_ch.kernel_value == 17'd65536)
                unit_seen++;
            if (kernels_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kernel_value %0d distance_saturated %0b",
                         $time, kernel_ch.kernel_value, kernel_ch.distance_saturated);
            end
            else
            begin
                want = kernels_due.pop_front();
                if (kernel_ch.kernel_value !== want.kv)
                begin
                    errors++;
                    $display("%0t: kernel_value expected %0d got %0d",
                             $time, want.kv, kernel_ch.kernel_value);
                end
                if (kernel_ch.distance_saturated !== want.sat)
                begin
                    errors++;
                    $display("%0t: distance_saturated expected %0b got %0b",
                             $time, want.sat, kernel_ch.distance_saturated);
                end
            end
        end
    end

endmodule
